[rtl/rsmp_pkg.sv]
// Package: constants, types and modular helpers for the rational series unit.
`timescale 1ns / 1ps
`default_nettype none
package rsmp_pkg;
  localparam int unsigned MaxOrderDefault = 64;
  localparam int unsigned MaxTapsDefault  = 32;
  localparam int unsigned ResW   = 30;
  localparam int unsigned IdxW   = 20;
  localparam int unsigned OrderW = 7;
  localparam int unsigned CountW = 21;
  localparam logic [ResW-1:0] PrimeMod = 30'd998244353;

  localparam logic CfgOrder     = 1'b0;
  localparam logic CfgTermCount = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_P_RD, ST_P_WAIT, ST_P_WR, ST_P_ROWEND, ST_P_TAPRD, ST_P_TAPWAIT,
    ST_P_TAPWR, ST_MAC_RD, ST_MAC_WAIT, ST_MAC_MUL, ST_MAC_RED, ST_NUM_RD, ST_NUM_WAIT,
    ST_OUT
  } rsmp_state_e;

  function automatic logic [ResW-1:0] add_mod(input logic [ResW-1:0] a,
                                              input logic [ResW-1:0] b);
    logic [ResW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PrimeMod}) s = s - {1'b0, PrimeMod};
    return s[ResW-1:0];
  endfunction

  function automatic logic [ResW-1:0] neg_mod(input logic [ResW-1:0] a);
    return (a == '0) ? '0 : PrimeMod - a;
  endfunction
endpackage
`default_nettype wire

[rtl/rsmp_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module rsmp_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/rsmp_modred.sv]
// Pipelined reduction of a 60-bit product modulo 998244353 (Barrett, two stages).
`timescale 1ns / 1ps
`default_nettype none
module rsmp_modred
  import rsmp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic [2*ResW-1:0]   prod_i,
  output logic      [ResW-1:0]     res_o
);
  // mu = floor(2^60 / p); quotient estimate from top 31 bits, error < 4.
  localparam logic [31:0] Mu = 32'd1154949187;
  logic [31:0]       hi;
  logic [63:0]       qm;
  logic [2*ResW-1:0] prod_q;
  logic [32:0]       qest_q;
  logic [2*ResW-1:0] qp;
  logic [33:0]       r0;
  logic [33:0]       r1;
  logic [33:0]       r2;
  logic [33:0]       r3;
  logic [33:0]       r4;
  logic [33:0]       pw;
  assign hi = {1'b0, prod_i[2*ResW-1:ResW-1]};
  assign qm = hi * Mu;
  always_ff @(posedge clk_i) begin
    prod_q <= prod_i;
    qest_q <= {1'b0, qm[62:31]};
  end
  assign qp = qest_q[29:0] * PrimeMod;
  assign pw = {4'b0, PrimeMod};
  always_comb begin
    r0 = prod_q[33:0] - qp[33:0];
    r1 = (r0 >= pw) ? r0 - pw : r0;
    r2 = (r1 >= pw) ? r1 - pw : r1;
    r3 = (r2 >= pw) ? r2 - pw : r2;
    r4 = (r3 >= pw) ? r3 - pw : r3;
  end
  always_ff @(posedge clk_i) res_o <= r4[ResW-1:0];
endmodule
`default_nettype wire

[rtl/rational_series_mod_prime_unit.sv]
// Top level: power-series P(t)/Q(t) coefficient generator modulo 998244353.
`timescale 1ns / 1ps
`default_nettype none
// One request transaction gives one coefficient transaction. The work for a normal request
// grows with D, the denominator tap count (up to MaxTaps), and no new request is taken until
// the result sits in the output register. The cost is set by the sequential loop that reads,
// multiplies and reduces over the history and the denominator tap RAM, whose one read port
// visits one tap per iteration; each tap beyond the first passes through read, RAM wait,
// multiply and reduction steps. A restart, or the first request after reset, first rebuilds
// the Pascal row in RAM by read-modify-write, with a denominator and a numerator tap capture
// per row. Order is clamped to 1..MaxOrder; taps above MaxTaps are dropped. The history sits
// in flip-flop shift cells (cleared by reset and restart); the Pascal row and both tap tables
// are registered-read RAMs. Config writes are taken only when idle.
module rational_series_mod_prime_unit
  import rsmp_pkg::*;
#(
  parameter int unsigned MaxOrder = MaxOrderDefault,
  parameter int unsigned MaxTaps  = MaxTapsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              restart_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [IdxW-1:0]        term_index_o,
  output logic [ResW-1:0]        coefficient_o,
  output logic                   last_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic              cfg_index_i,
  input  wire logic [CountW-1:0] cfg_data_i
);
  localparam int unsigned OW = $clog2(MaxOrder+1);
  localparam int unsigned PAW = $clog2(MaxOrder);
  localparam int unsigned TAW = (MaxTaps > 1) ? $clog2(MaxTaps) : 1;
  localparam int unsigned TDepth = (MaxTaps > 1) ? MaxTaps : 2;
  localparam int unsigned TCW = $clog2(MaxTaps+1);

  rsmp_state_e state_q, state_d;
  logic [OrderW-1:0] order_q;
  logic [CountW-1:0] term_count_q;
  logic [OW-1:0] k_q, r_q, j_q;
  logic [TCW-1:0] ncnt_q, dcnt_q, d_q;
  logic [IdxW-1:0] idx_q;
  logic taps_ready_q;
  logic [ResW-1:0] hist_q [MaxTaps];
  logic [ResW-1:0] acc_q, lo_q, coef_q;
  logic [2*ResW-1:0] prod_q;
  logic out_valid_q;
  logic [IdxW-1:0] oidx_q;
  logic [ResW-1:0] ocoef_q;
  logic olast_q;
  logic [1:0] wait_q;

  logic pw_we; logic [PAW-1:0] pw_a, pr_a; logic [ResW-1:0] pw_d, pr_q;
  logic nw_we, dw_we; logic [TAW-1:0] tw_a, nr_a, dr_a; logic [ResW-1:0] tw_d, nr_q, dr_q;
  logic [ResW-1:0] red;

  rsmp_ram #(.Width(ResW), .Depth(MaxOrder)) u_pascal (.clk_i, .we_i(pw_we), .waddr_i(pw_a),
    .wdata_i(pw_d), .raddr_i(pr_a), .rdata_o(pr_q));
  rsmp_ram #(.Width(ResW), .Depth(TDepth)) u_numer (.clk_i, .we_i(nw_we), .waddr_i(tw_a),
    .wdata_i(tw_d), .raddr_i(nr_a), .rdata_o(nr_q));
  rsmp_ram #(.Width(ResW), .Depth(TDepth)) u_denom (.clk_i, .we_i(dw_we), .waddr_i(tw_a),
    .wdata_i(tw_d), .raddr_i(dr_a), .rdata_o(dr_q));
  rsmp_modred u_red (.clk_i, .prod_i(prod_q), .res_o(red));

  // Tap captured at end of row r: denominator m=k-1-r, numerator m=k-2-r.
  logic [OW:0] dm, nm;
  logic dm_ok, nm_ok;
  assign dm = {1'b0, k_q} - {1'b0, r_q} - 1'b1;
  assign nm = {1'b0, k_q} - {1'b0, r_q} - 2'd2;
  assign dm_ok = (dm <= {1'b0, r_q}) && (dm < (OW+1)'(MaxTaps));
  assign nm_ok = !nm[OW] && (nm <= {1'b0, r_q}) && (nm < (OW+1)'(MaxTaps));
  logic capt_num_q; // second tap pass for numerator

  logic accept_in;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept_in = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE) && !out_valid_q;

  // Top entry of a row is a copy of its left neighbour; row 0 is just the leading 1.
  logic [ResW-1:0] pascal_wval;
  assign pascal_wval = (j_q == r_q) ? ((r_q == '0) ? ResW'(1) : lo_q) : add_mod(pr_q, lo_q);

  logic [OW-1:0] kclamp;
  always_comb begin
    kclamp = (order_q == '0) ? OW'(1) : OW'(order_q);
    if (int'(order_q) > int'(MaxOrder)) kclamp = OW'(MaxOrder);
  end

  always_comb begin
    state_d = state_q;
    pw_we = 1'b0; pw_a = PAW'(j_q); pr_a = PAW'(j_q); pw_d = pascal_wval;
    nw_we = 1'b0; dw_we = 1'b0; tw_a = '0; tw_d = neg_mod(pr_q);
    nr_a = TAW'(idx_q); dr_a = TAW'(d_q);
    case (state_q)
      ST_IDLE: if (accept_in) state_d = (restart_i || !taps_ready_q) ? ST_P_RD : ST_MAC_RD;
      ST_P_RD: begin pr_a = PAW'(j_q - 1'b1); state_d = ST_P_WAIT; end
      ST_P_WAIT: state_d = ST_P_WR;
      ST_P_WR: begin
        pw_we = 1'b1;
        state_d = (j_q <= OW'(1)) ? ST_P_ROWEND : ST_P_RD;
      end
      ST_P_ROWEND: state_d = ST_P_TAPRD;
      ST_P_TAPRD: begin
        pr_a = capt_num_q ? PAW'(nm) : PAW'(dm);
        state_d = ST_P_TAPWAIT;
      end
      ST_P_TAPWAIT: begin
        pr_a = capt_num_q ? PAW'(nm) : PAW'(dm);
        state_d = ST_P_TAPWR;
      end
      ST_P_TAPWR: begin
        tw_a = capt_num_q ? TAW'(nm) : TAW'(dm);
        // odd tap index carries a minus sign
        tw_d = (capt_num_q ? nm[0] : dm[0]) ? neg_mod(pr_q) : pr_q;
        nw_we = capt_num_q && nm_ok;
        dw_we = !capt_num_q && dm_ok;
        if (capt_num_q) state_d = (r_q + 1'b1 >= k_q) ? ST_MAC_RD : ST_P_RD;
        else state_d = ST_P_TAPRD;
      end
      ST_MAC_RD: state_d = (d_q >= dcnt_q) ? ST_NUM_RD : ST_MAC_WAIT;
      ST_MAC_WAIT: state_d = ST_MAC_MUL;
      ST_MAC_MUL: state_d = ST_MAC_RED;
      ST_MAC_RED: if (wait_q == 2'd2) state_d = ST_MAC_RD;
      ST_NUM_RD: state_d = ST_NUM_WAIT;
      ST_NUM_WAIT: state_d = ST_OUT;
      ST_OUT: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; order_q <= OrderW'(2); term_count_q <= CountW'(16);
      taps_ready_q <= 1'b0; idx_q <= '0; out_valid_q <= 1'b0; ncnt_q <= '0; dcnt_q <= '0;
      k_q <= '0; r_q <= '0; j_q <= '0; d_q <= '0; wait_q <= '0; capt_num_q <= 1'b0;
      for (int i = 0; i < int'(MaxTaps); i++) hist_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgOrder) order_q <= cfg_data_i[OrderW-1:0];
        else term_count_q <= cfg_data_i;
      end
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (accept_in) begin
          d_q <= TCW'(1); acc_q <= '0; wait_q <= '0;
          if (restart_i || !taps_ready_q) begin
            k_q <= kclamp; r_q <= '0; j_q <= '0; capt_num_q <= 1'b0;
          end
          if (restart_i) begin
            idx_q <= '0;
            for (int i = 0; i < int'(MaxTaps); i++) hist_q[i] <= '0;
          end
        end
        ST_P_WAIT: lo_q <= pr_q;
        ST_P_WR: if (j_q > OW'(1)) j_q <= j_q - 1'b1;
        ST_P_TAPWR: begin
          capt_num_q <= !capt_num_q;
          if (capt_num_q) begin
            r_q <= r_q + 1'b1; j_q <= r_q + 1'b1;
            if (r_q + 1'b1 >= k_q) begin
              taps_ready_q <= 1'b1;
              ncnt_q <= ((k_q >> 1) > OW'(MaxTaps)) ? TCW'(MaxTaps) : TCW'(k_q >> 1);
              dcnt_q <= ((({1'b0, k_q} + 1'b1) >> 1) > (OW+1)'(MaxTaps)) ? TCW'(MaxTaps)
                        : TCW'(({1'b0, k_q} + 1'b1) >> 1);
            end
          end
        end
        ST_MAC_MUL: prod_q <= (2*ResW)'(hist_q[TAW'(d_q - 1'b1)]) * (2*ResW)'(dr_q);
        ST_MAC_RED: begin
          wait_q <= wait_q + 1'b1;
          if (wait_q == 2'd2) begin
            acc_q <= add_mod(acc_q, red); d_q <= d_q + 1'b1; wait_q <= '0;
          end
        end
        ST_NUM_WAIT: coef_q <= add_mod(({1'b0, idx_q} < (IdxW+1)'(ncnt_q)) ? nr_q : '0,
                                       neg_mod(acc_q));
        ST_OUT: if (!out_valid_q || !out_stall_i) begin
          oidx_q <= idx_q; ocoef_q <= coef_q;
          olast_q <= (term_count_q != '0) && ({1'b0, idx_q} == term_count_q - 1'b1);
          idx_q <= idx_q + 1'b1;
          hist_q[0] <= coef_q;
          for (int i = 1; i < int'(MaxTaps); i++) hist_q[i] <= hist_q[i-1];
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign term_index_o = oidx_q;
  assign last_o = olast_q;
  assign coefficient_o = ocoef_q;

`ifndef NO_ASSERTIONS
  a_no_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cfg_ready_o) else $error("cfg taken while busy");
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && state_d == ST_IDLE) |=> out_valid_q) else $error("result lost");
  a_coef_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (coefficient_o < PrimeMod)) else $error("non-canonical residue");
`endif
endmodule
`default_nettype wire

[tb/testbench.sv]
// Testbench for rational_series_mod_prime_unit: directed and random requests checked on the fly.
`timescale 1ns / 1ps
module testbench
  import rsmp_pkg::*;
();

  localparam longint unsigned Prime      = 64'd998244353;
  localparam int              NumTaps    = 32;
  localparam int              RowLen     = 64;
  localparam int              RandomReqs = 1300;
  // The limit covers the worst case: a restart at order 64 plus 32-tap
  // requests with both sides idling.
  localparam longint          CycleLimit = 64'd6000000;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [ResW-1:0] coef;
    logic            last;
  } coef_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              restart_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [IdxW-1:0]   term_index_o;
  logic [ResW-1:0]   coefficient_o;
  logic              last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = CfgOrder;
  logic [CountW-1:0] cfg_data_i = '0;

  rational_series_mod_prime_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .restart_i,
    .out_valid_o, .out_stall_i, .term_index_o, .coefficient_o, .last_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: live registers, plus the taps captured at the last rebuild.
  logic [OrderW-1:0]  cur_order;
  logic [CountW-1:0]  cur_count;
  longint unsigned    pascal[RowLen];
  longint unsigned    numer_tap[NumTaps];
  longint unsigned    denom_tap[NumTaps];
  int                 numer_n, denom_n;
  longint unsigned    recent[NumTaps];  // newest coefficient first
  logic [IdxW-1:0]    next_idx;
  bit                 taps_built;

  coef_t   pending[$];
  int      err_count = 0;
  longint  cycles = 0;
  bit      hold_req = 1'b0;  // asks the receiver for one long hold-off

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint unsigned signed_tap(longint unsigned v, int m);
    return ((m % 2) == 1 && v != 0) ? Prime - v : v;
  endfunction

  // Rebuild the Pascal row and both tap tables from the current order.
  task automatic rebuild_taps();
    int k, m;
    k = cur_order;
    if (k < 1) k = 1;
    if (k > RowLen) k = RowLen;
    pascal[0] = 1;
    for (int r = 0; r < k; r++) begin
      if (r > 0) begin
        pascal[r] = 0;
        for (int j = r; j >= 1; j--) pascal[j] = (pascal[j] + pascal[j-1]) % Prime;
      end
      m = k - 1 - r;
      if (m <= r && m < NumTaps) denom_tap[m] = signed_tap(pascal[m], m);
      if (k >= 2 + r) begin
        m = k - 2 - r;
        if (m <= r && m < NumTaps) numer_tap[m] = signed_tap(pascal[m], m);
      end
    end
    numer_n = (k / 2 > NumTaps) ? NumTaps : k / 2;
    denom_n = ((k + 1) / 2 > NumTaps) ? NumTaps : (k + 1) / 2;
    taps_built = 1'b1;
  endtask

  // Next series coefficient for one accepted request.
  task automatic predict_coef(input bit rst_req, output coef_t res);
    longint unsigned acc, num, c;
    if (rst_req) begin
      rebuild_taps();
      foreach (recent[d]) recent[d] = 0;
      next_idx = '0;
    end else if (!taps_built) begin
      rebuild_taps();
    end
    acc = 0;
    for (int d = 1; d < denom_n; d++) acc = (acc + recent[d-1] * denom_tap[d]) % Prime;
    num = (next_idx < numer_n) ? numer_tap[next_idx] : 0;
    c = (num + Prime - acc) % Prime;
    for (int d = NumTaps - 1; d >= 1; d--) recent[d] = recent[d-1];
    recent[0] = c;
    res.idx  = next_idx;
    res.coef = c[ResW-1:0];
    res.last = (cur_count != 0) && ({1'b0, next_idx} == cur_count - 1);
    next_idx = next_idx + 1'b1;
  endtask

  // One request transaction, preceded by a random gap. Valid stays high
  // between back-to-back requests.
  task automatic send_request(input bit rst_req);
    int gap;
    coef_t res;
    gap = $urandom_range(7);
    if ($urandom_range(3) == 0) gap = 0;  // runs without idling
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rst_req;
    do @(posedge clk_i); while (in_stall_o);
    predict_coef(rst_req, res);
    pending = {pending, res};
  endtask

  // Register writes only once every expected coefficient has come back.
  task automatic write_reg(input logic idx, input logic [CountW-1:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgOrder) cur_order = data[OrderW-1:0];
    else cur_count = data;
  endtask

  // Receiver: random stall per transaction, one long hold-off on request.
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = $urandom_range(7);
      if ($urandom_range(3) == 0) hold = 0;
      if (hold_req) begin
        hold = 400;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    coef_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected coefficient idx=%0d coef=%0d", $time, term_index_o,
                 coefficient_o);
        err_count++;
      end else begin
        want = pending.pop_front();
        if (term_index_o !== want.idx) begin
          $display("%0t: term_index expected %0d actual %0d", $time, want.idx, term_index_o);
          err_count++;
        end
        if (coefficient_o !== want.coef) begin
          $display("%0t: coefficient expected %0d actual %0d", $time, want.coef,
                   coefficient_o);
          err_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
          err_count++;
        end
      end
    end
  end

  // First request after reset has no restart: taps must be built anyway.
  task automatic test_first_request();
    repeat (4) send_request(1'b0);
    send_request(1'b1);
  endtask

  // Order extremes, clamping and term_count extremes.
  task automatic test_config_extremes();
    write_reg(CfgOrder, 21'd1);
    write_reg(CfgTermCount, 21'd1);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(CfgOrder, 21'd64);
    write_reg(CfgTermCount, 21'd0);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    write_reg(CfgOrder, 21'd0);  // treated as order 1
    write_reg(CfgTermCount, 21'd1048576);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(CfgOrder, 21'd127);  // treated as order 64
    write_reg(CfgTermCount, 21'h1FFFFF);
    send_request(1'b1);
    send_request(1'b0);
    write_reg(CfgOrder, 21'd5);
    write_reg(CfgTermCount, 21'd3);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
  endtask

  // A new order without restart leaves the taps alone; last follows term_count at once.
  task automatic test_midrun_config();
    write_reg(CfgOrder, 21'd9);
    write_reg(CfgTermCount, 21'd7);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // Long receiver hold-off while requests keep coming: the input must stall.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) send_request(1'b0);
  endtask

  // Random phases: mostly small orders, the odd large one; restarts now and then.
  task automatic test_random();
    int sent, burst, ord;
    sent = 0;
    while (sent < RandomReqs) begin
      ord = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 14);
      write_reg(CfgOrder, 21'(ord));
      case ($urandom_range(5))
        0:       write_reg(CfgTermCount, 21'($urandom));
        1:       write_reg(CfgTermCount, 21'd0);
        default: write_reg(CfgTermCount, 21'($urandom_range(1, 40)));
      endcase
      burst = $urandom_range(20, 70);
      send_request($urandom_range(4) != 0);
      for (int n = 1; n < burst; n++) send_request($urandom_range(24) == 0);
      sent += burst;
    end
  endtask

  initial begin
    cur_order  = 7'd2;
    cur_count  = 21'd16;
    numer_n    = 0;
    denom_n    = 0;
    next_idx   = '0;
    taps_built = 1'b0;
    foreach (recent[d]) recent[d] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_request();
    test_config_extremes();
    test_midrun_config();
    test_backpressure();
    test_random();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[rational_series_mod_prime_unit.f]
rtl/rsmp_pkg.sv
rtl/rsmp_ram.sv
rtl/rsmp_modred.sv
rtl/rational_series_mod_prime_unit.sv
tb/testbench.sv
